[hdl/uosg_pkg.sv]
// Shared types and constants for the obstacle speed governor.
`timescale 1ns / 1ps

package uosg_pkg;

  // Field widths
  localparam int unsigned DIST_W  = 15;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned ECHO_W  = 16;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned RPM_W   = 7;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Median set size and sample counter width
  localparam int unsigned MEDIAN_TAPS = 3;
  localparam int unsigned CNT_W       = 2;

  // Echo conversion: distance = (echo * ECHO_SCALE) >> ECHO_SHIFT
  localparam int unsigned ECHO_SCALE = 281;
  localparam int unsigned ECHO_SHIFT = 10;
  localparam int unsigned PROD_W     = 25;

  localparam logic [DIST_W-1:0] MAX_VALID = 15'd4800;

  // Command bytes
  localparam logic [CMD_W-1:0] CMD_START = 8'h31;
  localparam logic [CMD_W-1:0] CMD_STOP  = 8'h30;

  // Wheel speed commands
  localparam logic [RPM_W-1:0] RPM_ZERO   = 7'd0;
  localparam logic [RPM_W-1:0] RPM_SLOW   = 7'd60;
  localparam logic [RPM_W-1:0] RPM_CRUISE = 7'd70;
  localparam logic [RPM_W-1:0] RPM_FAST   = 7'd120;

  // Register reset values
  localparam logic [DIST_W-1:0] RST_STOP_BELOW   = 15'd480;
  localparam logic [DIST_W-1:0] RST_TURN_BELOW   = 15'd960;
  localparam logic [DIST_W-1:0] RST_CRUISE_BELOW = 15'd1920;
  localparam logic [DIST_W-1:0] RST_JUMP_LIMIT   = 15'd480;
  localparam logic [DIST_W-1:0] RST_MIN_VALID    = 15'd160;
  localparam logic [MS_W-1:0]   RST_STALE_MS     = 16'd300;
  localparam logic [MS_W-1:0]   RST_TURN_GAP_MS  = 16'd500;
  localparam logic [MS_W-1:0]   RST_COOLDOWN_MS  = 16'd700;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BELOW   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_BELOW   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_BELOW = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_MS     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAP_MS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS  = 4'd7;

  // Motion codes
  typedef enum logic [1:0] {
    MOT_NONE = 2'd0,
    MOT_STOP = 2'd1,
    MOT_FWD  = 2'd2,
    MOT_TURN = 2'd3
  } motion_t;

  typedef logic [DIST_W-1:0] sample_arr_t [MEDIAN_TAPS];

  // Result of the sample path for one beat
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] stamp;
    logic              wr;
    logic [CNT_W-1:0]  wr_idx;
    logic [DIST_W-1:0] wr_data;
    logic              med_vld;
    logic              med_acc;
    logic [DIST_W-1:0] med;
  } samp_res_t;

  // Result of the zone decision for one beat
  typedef struct packed {
    motion_t           motion;
    logic [RPM_W-1:0]  rpm;
    logic [DIST_W-1:0] used_dist;
    logic              turn;
  } zone_res_t;

endpackage

[hdl/uosg_sample.sv]
// Echo conversion, sample validation, stale handling and median of three.
`timescale 1ns / 1ps

module uosg_sample (
  input  logic                          en,
  input  logic [uosg_pkg::TIME_W-1:0]   now_ms,
  input  logic                          has_echo,
  input  logic [uosg_pkg::ECHO_W-1:0]   echo_width_us,
  input  logic [uosg_pkg::CNT_W-1:0]    cnt,
  input  logic [uosg_pkg::TIME_W-1:0]   stamp,
  input  uosg_pkg::sample_arr_t         store,
  input  logic                          last_known,
  input  logic [uosg_pkg::DIST_W-1:0]   last_distance,
  input  logic                          skip_jump,
  input  logic [uosg_pkg::DIST_W-1:0]   jump_limit,
  input  logic [uosg_pkg::DIST_W-1:0]   min_valid,
  input  logic [uosg_pkg::MS_W-1:0]     stale_ms,
  output uosg_pkg::samp_res_t           res
);

  // True when a distance moves too far from the last accepted one.
  function automatic logic too_far(
    input logic [uosg_pkg::DIST_W-1:0] d,
    input logic                        known,
    input logic [uosg_pkg::DIST_W-1:0] last,
    input logic [uosg_pkg::DIST_W-1:0] lim
  );
    logic [uosg_pkg::DIST_W-1:0] diff;
    diff = (d > last) ? (d - last) : (last - d);
    return known && (last != '0) && (diff > lim);
  endfunction

  // Middle value of three, by a three-swap sort.
  function automatic logic [uosg_pkg::DIST_W-1:0] mid3(
    input logic [uosg_pkg::DIST_W-1:0] a,
    input logic [uosg_pkg::DIST_W-1:0] b,
    input logic [uosg_pkg::DIST_W-1:0] c
  );
    logic [uosg_pkg::DIST_W-1:0] x, y, z, t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    return y;
  endfunction

  logic [uosg_pkg::PROD_W-1:0] prod;
  logic [uosg_pkg::DIST_W-1:0] sample_dist;
  logic [uosg_pkg::TIME_W-1:0] age;
  logic                        stale;
  logic [uosg_pkg::CNT_W-1:0]  cnt_a;
  logic [uosg_pkg::CNT_W-1:0]  idx;
  logic [uosg_pkg::CNT_W-1:0]  cnt_b;
  logic                        in_range;
  logic                        ok;
  logic                        full;
  logic [uosg_pkg::DIST_W-1:0] med;

  // Scale the echo width to 1/16 cm.
  assign prod = {{(uosg_pkg::PROD_W - uosg_pkg::ECHO_W){1'b0}}, echo_width_us}
              * uosg_pkg::PROD_W'(uosg_pkg::ECHO_SCALE);
  assign sample_dist = prod[uosg_pkg::ECHO_SHIFT +: uosg_pkg::DIST_W];

  // Drop a partial set that has gone stale.
  assign age   = now_ms - stamp;
  assign stale = (cnt != '0) && (age > {{(uosg_pkg::TIME_W - uosg_pkg::MS_W){1'b0}}, stale_ms});
  assign cnt_a = stale ? '0 : cnt;

  // Range and jump checks on the raw sample.
  assign in_range = (sample_dist >= min_valid) && (sample_dist <= uosg_pkg::MAX_VALID);
  assign ok = en && has_echo && in_range
           && (skip_jump || !too_far(sample_dist, last_known, last_distance, jump_limit));

  // Slot for the new sample; the set is full once the last slot is written.
  assign idx   = (cnt_a >= uosg_pkg::CNT_W'(uosg_pkg::MEDIAN_TAPS)) ? '0 : cnt_a;
  assign cnt_b = idx + 1'b1;
  assign full  = ok && (cnt_b == uosg_pkg::CNT_W'(uosg_pkg::MEDIAN_TAPS));
  assign med   = mid3(store[0], store[1], sample_dist);

  // Collect the results of this beat.
  always_comb begin
    res.wr      = ok;
    res.wr_idx  = idx;
    res.wr_data = sample_dist;
    res.med_vld = full;
    res.med     = med;
    res.med_acc = full && (skip_jump || !too_far(med, last_known, last_distance, jump_limit));
    res.stamp   = ok ? now_ms : stamp;
    if (!en) begin
      res.cnt = cnt;
    end else if (full) begin
      res.cnt = '0;
    end else if (ok) begin
      res.cnt = cnt_b;
    end else begin
      res.cnt = cnt_a;
    end
  end

endmodule

[hdl/uosg_zone.sv]
// Distance zone decision and result selection for one beat.
`timescale 1ns / 1ps

module uosg_zone (
  input  logic                        running,
  input  logic                        have_dist,
  input  logic [uosg_pkg::DIST_W-1:0] dist_in,
  input  logic [uosg_pkg::TIME_W-1:0] now_ms,
  input  logic [uosg_pkg::TIME_W-1:0] next_turn_time,
  input  logic [uosg_pkg::DIST_W-1:0] stop_below,
  input  logic [uosg_pkg::DIST_W-1:0] turn_below,
  input  logic [uosg_pkg::DIST_W-1:0] cruise_below,
  output uosg_pkg::zone_res_t         res
);

  logic turn_ok;

  assign turn_ok = now_ms >= next_turn_time;

  // Zones are tested in order stop, turn, cruise; the first match wins.
  always_comb begin
    res.motion    = uosg_pkg::MOT_NONE;
    res.rpm       = uosg_pkg::RPM_ZERO;
    res.used_dist = '0;
    res.turn      = 1'b0;
    priority if (!running) begin
      res.motion = uosg_pkg::MOT_STOP;
    end else if (!have_dist) begin
      res.motion = uosg_pkg::MOT_NONE;
    end else if (dist_in < stop_below) begin
      res.motion    = uosg_pkg::MOT_STOP;
      res.used_dist = dist_in;
    end else if (dist_in < turn_below) begin
      res.used_dist = dist_in;
      if (turn_ok) begin
        res.motion = uosg_pkg::MOT_TURN;
        res.turn   = 1'b1;
      end else begin
        res.motion = uosg_pkg::MOT_FWD;
        res.rpm    = uosg_pkg::RPM_SLOW;
      end
    end else if (dist_in < cruise_below) begin
      res.motion    = uosg_pkg::MOT_FWD;
      res.rpm       = uosg_pkg::RPM_CRUISE;
      res.used_dist = dist_in;
    end else begin
      res.motion    = uosg_pkg::MOT_FWD;
      res.rpm       = uosg_pkg::RPM_FAST;
      res.used_dist = dist_in;
    end
  end

endmodule

[hdl/ultrasonic_obstacle_speed_governor_unit.sv]
// Top level of the ultrasonic obstacle speed governor.
`timescale 1ns / 1ps

// Turns a stream of passes (time stamp, optional start/stop byte, optional echo
// width) into one motion command per pass: none, stop, forward at 60/70/120 rpm,
// or a rate-limited turn, driven by the median of three validated echo
// distances in 1/16 cm. Every input beat gives exactly one result beat. A beat
// is taken into an input register, processed combinationally against the block
// state, and its result lands in the output register when the beat advances,
// which waits while an unread result holds it; a new beat is accepted every
// cycle while the output register is free or drains, and the input side keeps
// accepting while a result waits as long as the output register is emptied in
// the same cycle.
// Configuration writes are always ready and take effect on the next beat; they
// should be made only while no beat is in flight.

module ultrasonic_obstacle_speed_governor_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [uosg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uosg_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [uosg_pkg::TIME_W-1:0]      in_now_ms,
  input  logic                             in_has_cmd,
  input  logic [uosg_pkg::CMD_W-1:0]       in_cmd_byte,
  input  logic                             in_has_echo,
  input  logic [uosg_pkg::ECHO_W-1:0]      in_echo_width_us,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_motion,
  output logic [uosg_pkg::RPM_W-1:0]       out_wheel_rpm,
  output logic [uosg_pkg::DIST_W-1:0]      out_distance_used
);

  // Configuration registers
  logic [uosg_pkg::DIST_W-1:0] stop_below_r, turn_below_r, cruise_below_r;
  logic [uosg_pkg::DIST_W-1:0] jump_limit_r, min_valid_r;
  logic [uosg_pkg::MS_W-1:0]   stale_ms_r, turn_gap_ms_r, cooldown_ms_r;

  // Input stage
  logic                        in_valid_r;
  logic [uosg_pkg::TIME_W-1:0] now_r;
  logic                        has_cmd_r;
  logic [uosg_pkg::CMD_W-1:0]  cmd_r;
  logic                        has_echo_r;
  logic [uosg_pkg::ECHO_W-1:0] echo_r;

  // Block state
  logic                        run_r;
  uosg_pkg::sample_arr_t       store_r;
  logic [uosg_pkg::CNT_W-1:0]  cnt_r;
  logic [uosg_pkg::DIST_W-1:0] last_r;
  logic                        known_r;
  logic [uosg_pkg::TIME_W-1:0] stamp_r;
  logic [uosg_pkg::TIME_W-1:0] cool_r;
  logic [uosg_pkg::TIME_W-1:0] next_turn_r;

  logic                        run_nxt;
  logic [uosg_pkg::CNT_W-1:0]  cnt_nxt;
  logic [uosg_pkg::DIST_W-1:0] last_nxt;
  logic                        known_nxt;
  logic [uosg_pkg::TIME_W-1:0] stamp_nxt;
  logic [uosg_pkg::TIME_W-1:0] cool_nxt;
  logic [uosg_pkg::TIME_W-1:0] next_turn_nxt;

  // Output stage
  logic                        out_valid_r;
  logic [1:0]                  out_motion_r;
  logic [uosg_pkg::RPM_W-1:0]  out_rpm_r;
  logic [uosg_pkg::DIST_W-1:0] out_dist_r;

  // Beat flow
  logic advance;
  logic cfg_we;

  // Per-beat working values
  logic                        cmd_hit;
  logic                        run_c;
  logic                        known_c;
  logic [uosg_pkg::CNT_W-1:0]  cnt_c;
  logic [uosg_pkg::TIME_W-1:0] stamp_c;
  logic                        skip_jump;
  logic                        have_dist;
  logic [uosg_pkg::DIST_W-1:0] dist_sel;
  uosg_pkg::samp_res_t         samp;
  uosg_pkg::zone_res_t         zone;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // The input register moves on whenever the output register is free or drains.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || !out_valid_r || out_ready;

  // Configuration register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_below_r   <= uosg_pkg::RST_STOP_BELOW;
      turn_below_r   <= uosg_pkg::RST_TURN_BELOW;
      cruise_below_r <= uosg_pkg::RST_CRUISE_BELOW;
      jump_limit_r   <= uosg_pkg::RST_JUMP_LIMIT;
      min_valid_r    <= uosg_pkg::RST_MIN_VALID;
      stale_ms_r     <= uosg_pkg::RST_STALE_MS;
      turn_gap_ms_r  <= uosg_pkg::RST_TURN_GAP_MS;
      cooldown_ms_r  <= uosg_pkg::RST_COOLDOWN_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uosg_pkg::CFG_STOP_BELOW:   stop_below_r   <= cfg_data[uosg_pkg::DIST_W-1:0];
        uosg_pkg::CFG_TURN_BELOW:   turn_below_r   <= cfg_data[uosg_pkg::DIST_W-1:0];
        uosg_pkg::CFG_CRUISE_BELOW: cruise_below_r <= cfg_data[uosg_pkg::DIST_W-1:0];
        uosg_pkg::CFG_JUMP_LIMIT:   jump_limit_r   <= cfg_data[uosg_pkg::DIST_W-1:0];
        uosg_pkg::CFG_MIN_VALID:    min_valid_r    <= cfg_data[uosg_pkg::DIST_W-1:0];
        uosg_pkg::CFG_STALE_MS:     stale_ms_r     <= cfg_data[uosg_pkg::MS_W-1:0];
        uosg_pkg::CFG_TURN_GAP_MS:  turn_gap_ms_r  <= cfg_data[uosg_pkg::MS_W-1:0];
        uosg_pkg::CFG_COOLDOWN_MS:  cooldown_ms_r  <= cfg_data[uosg_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r      <= in_now_ms;
      has_cmd_r  <= in_has_cmd;
      cmd_r      <= in_cmd_byte;
      has_echo_r <= in_has_echo;
      echo_r     <= in_echo_width_us;
    end
  end

  // A start or stop byte restarts the sample set and forgets the distance.
  assign cmd_hit = has_cmd_r
                && ((cmd_r == uosg_pkg::CMD_START) || (cmd_r == uosg_pkg::CMD_STOP));
  assign run_c   = cmd_hit ? (cmd_r == uosg_pkg::CMD_START) : run_r;
  assign known_c = cmd_hit ? 1'b0 : known_r;
  assign cnt_c   = cmd_hit ? '0 : cnt_r;
  assign stamp_c = cmd_hit ? now_r : stamp_r;

  assign skip_jump = now_r < cool_r;

  uosg_sample u_sample (
    .en            (run_c),
    .now_ms        (now_r),
    .has_echo      (has_echo_r),
    .echo_width_us (echo_r),
    .cnt           (cnt_c),
    .stamp         (stamp_c),
    .store         (store_r),
    .last_known    (known_c),
    .last_distance (last_r),
    .skip_jump     (skip_jump),
    .jump_limit    (jump_limit_r),
    .min_valid     (min_valid_r),
    .stale_ms      (stale_ms_r),
    .res           (samp)
  );

  // A fresh median drives this beat even when its jump check fails.
  assign have_dist = known_c || samp.med_vld;
  assign dist_sel  = samp.med_vld ? samp.med : last_r;

  uosg_zone u_zone (
    .running        (run_c),
    .have_dist      (have_dist),
    .dist_in        (dist_sel),
    .now_ms         (now_r),
    .next_turn_time (next_turn_r),
    .stop_below     (stop_below_r),
    .turn_below     (turn_below_r),
    .cruise_below   (cruise_below_r),
    .res            (zone)
  );

  // Next state; a turn restarts sampling and arms the gap and cooldown timers.
  always_comb begin
    run_nxt       = run_c;
    cnt_nxt       = samp.cnt;
    stamp_nxt     = samp.stamp;
    last_nxt      = samp.med_acc ? samp.med : last_r;
    known_nxt     = samp.med_acc ? 1'b1 : known_c;
    cool_nxt      = cool_r;
    next_turn_nxt = next_turn_r;
    if (zone.turn) begin
      next_turn_nxt = now_r + {{(uosg_pkg::TIME_W - uosg_pkg::MS_W){1'b0}}, turn_gap_ms_r};
      cool_nxt      = now_r + {{(uosg_pkg::TIME_W - uosg_pkg::MS_W){1'b0}}, cooldown_ms_r};
      cnt_nxt       = '0;
      last_nxt      = '0;
      known_nxt     = 1'b1;
      stamp_nxt     = now_r;
    end
  end

  // State registers, updated once per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      cnt_r       <= '0;
      last_r      <= '0;
      known_r     <= 1'b0;
      stamp_r     <= '0;
      cool_r      <= '0;
      next_turn_r <= '0;
      store_r     <= '{default: '0};
    end else if (advance) begin
      run_r       <= run_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      known_r     <= known_nxt;
      stamp_r     <= stamp_nxt;
      cool_r      <= cool_nxt;
      next_turn_r <= next_turn_nxt;
      if (samp.wr) begin
        store_r[samp.wr_idx] <= samp.wr_data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_motion_r <= zone.motion;
      out_rpm_r    <= zone.rpm;
      out_dist_r   <= zone.used_dist;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motion        = out_motion_r;
  assign out_wheel_rpm     = out_rpm_r;
  assign out_distance_used = out_dist_r;

  // The sample counter is cleared before it can reach the set size.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != uosg_pkg::CNT_W'(uosg_pkg::MEDIAN_TAPS))
    else $error("sample counter reached the set size");

  // An empty output register never blocks the input side.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

  // A turn forgets the distance but marks it known, so later beats use distance zero until a new median.
  a_turn_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && zone.turn) |=> (known_r && (last_r == '0) && (cnt_r == '0)))
    else $error("turn did not reset the distance state");

  // A beat processed while stopped gives a stop result with no distance.
  a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !run_c) |=> (out_valid_r && (out_motion_r == uosg_pkg::MOT_STOP)
                             && (out_dist_r == '0) && (out_rpm_r == uosg_pkg::RPM_ZERO)))
    else $error("stopped beat gave a non-stop result");

endmodule

[tb/uosg_decision_checker.sv]
// Watches the channels of the speed governor, predicts each decision and compares it.
`timescale 1ns / 1ps

module uosg_decision_checker
  import uosg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  in_has_cmd,
  input  logic [CMD_W-1:0]      in_cmd_byte,
  input  logic                  in_has_echo,
  input  logic [ECHO_W-1:0]     in_echo_width_us,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_motion,
  input  logic [RPM_W-1:0]      out_wheel_rpm,
  input  logic [DIST_W-1:0]     out_distance_used,
  output int unsigned           beats_pending,
  output int unsigned           mismatches
);

  // One expected decision
  typedef struct packed {
    motion_t           motion;
    logic [RPM_W-1:0]  rpm;
    logic [DIST_W-1:0] used_dist;
  } decision_t;

  // Shadow copy of the configuration registers
  logic [DIST_W-1:0] stop_thr, turn_thr, cruise_thr, jump_max, min_dist;
  logic [MS_W-1:0]   stale_age, turn_gap, cool_len;

  // Shadow copy of the governor state
  logic              motor_on;
  logic [DIST_W-1:0] taps [MEDIAN_TAPS];
  logic [CNT_W-1:0]  tap_cnt;
  logic [DIST_W-1:0] held_dist;
  logic              held_valid;
  logic [TIME_W-1:0] last_tap_ms;
  logic [TIME_W-1:0] cool_until;
  logic [TIME_W-1:0] turn_ok_at;

  decision_t   expected_cmds [$];
  int unsigned err_total = 0;

  // True when a distance strays too far from the held one.
  function automatic logic jump_too_far(input logic [DIST_W-1:0] d);
    logic [DIST_W-1:0] diff;
    if (!held_valid || held_dist == '0) return 1'b0;
    diff = (d > held_dist) ? d - held_dist : held_dist - d;
    return diff > jump_max;
  endfunction

  // Advances the shadow state by one pass and returns the decision it yields.
  function automatic decision_t govern_pass(input logic [TIME_W-1:0] now,
                                            input logic              has_cmd,
                                            input logic [CMD_W-1:0]  cmd,
                                            input logic              has_echo,
                                            input logic [ECHO_W-1:0] echo);
    decision_t         res;
    logic              have_dist, skip_jump, ok;
    logic [DIST_W-1:0] cur_dist, d, a, b, c, m;
    logic [PROD_W-1:0] prod;
    logic [TIME_W-1:0] age;
    res        = '0;
    res.motion = MOT_NONE;

    // A start or stop byte restarts sample gathering.
    if (has_cmd && (cmd == CMD_START || cmd == CMD_STOP)) begin
      motor_on    = (cmd == CMD_START);
      held_valid  = 1'b0;
      tap_cnt     = '0;
      last_tap_ms = now;
    end
    if (!motor_on) begin
      res.motion = MOT_STOP;
      return res;
    end

    have_dist = held_valid;
    cur_dist  = held_dist;

    // Drop a partial set that has gone stale.
    age = now - last_tap_ms;
    if (tap_cnt != '0 && age > TIME_W'(stale_age)) tap_cnt = '0;

    skip_jump = now < cool_until;

    // Validate the echo and gather it into the median set.
    if (has_echo) begin
      prod = PROD_W'(echo * ECHO_SCALE);
      d    = prod[PROD_W-1:ECHO_SHIFT];
      ok   = d >= min_dist && d <= MAX_VALID;
      if (ok && !skip_jump && jump_too_far(d)) ok = 1'b0;
      if (ok) begin
        taps[tap_cnt] = d;
        tap_cnt       = tap_cnt + 1'b1;
        last_tap_ms   = now;
        if (tap_cnt == MEDIAN_TAPS) begin
          tap_cnt = '0;
          a = taps[0];
          b = taps[1];
          c = taps[2];
          if (a > b) m = (b > c) ? b : ((a > c) ? c : a);
          else       m = (a > c) ? a : ((b > c) ? c : b);
          cur_dist  = m;
          have_dist = 1'b1;
          if (skip_jump || !jump_too_far(m)) begin
            held_dist  = m;
            held_valid = 1'b1;
          end
        end
      end
    end

    if (!have_dist) return res;

    // Zone decision, tested in the order stop, turn, cruise.
    res.used_dist = cur_dist;
    if (cur_dist < stop_thr) begin
      res.motion = MOT_STOP;
    end else if (cur_dist < turn_thr) begin
      if (now >= turn_ok_at) begin
        turn_ok_at  = now + turn_gap;
        cool_until  = now + cool_len;
        tap_cnt     = '0;
        held_dist   = '0;
        held_valid  = 1'b1;
        last_tap_ms = now;
        res.motion  = MOT_TURN;
      end else begin
        res.motion = MOT_FWD;
        res.rpm    = RPM_SLOW;
      end
    end else if (cur_dist < cruise_thr) begin
      res.motion = MOT_FWD;
      res.rpm    = RPM_CRUISE;
    end else begin
      res.motion = MOT_FWD;
      res.rpm    = RPM_FAST;
    end
    return res;
  endfunction

  // Channel monitor: results are checked before new passes are queued.
  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      stop_thr    = RST_STOP_BELOW;
      turn_thr    = RST_TURN_BELOW;
      cruise_thr  = RST_CRUISE_BELOW;
      jump_max    = RST_JUMP_LIMIT;
      min_dist    = RST_MIN_VALID;
      stale_age   = RST_STALE_MS;
      turn_gap    = RST_TURN_GAP_MS;
      cool_len    = RST_COOLDOWN_MS;
      motor_on    = 1'b0;
      taps[0]     = '0;
      taps[1]     = '0;
      taps[2]     = '0;
      tap_cnt     = '0;
      held_dist   = '0;
      held_valid  = 1'b0;
      last_tap_ms = '0;
      cool_until  = '0;
      turn_ok_at  = '0;
      expected_cmds.delete();
    end else begin
      // Result beat against the oldest expectation.
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected result beat: motion %0d rpm %0d distance %0d",
                 out_motion, out_wheel_rpm, out_distance_used);
          err_total++;
        end else begin
          want = expected_cmds.pop_front();
          if (out_motion !== want.motion) begin
            $error("motion: expected %0d, actual %0d", want.motion, out_motion);
            err_total++;
          end
          if (out_wheel_rpm !== want.rpm) begin
            $error("wheel_rpm: expected %0d, actual %0d", want.rpm, out_wheel_rpm);
            err_total++;
          end
          if (out_distance_used !== want.used_dist) begin
            $error("distance_used: expected %0d, actual %0d", want.used_dist,
                   out_distance_used);
            err_total++;
          end
        end
      end

      // Input beat: predict its decision.
      if (in_valid && in_ready)
        expected_cmds.push_back(govern_pass(in_now_ms, in_has_cmd, in_cmd_byte,
                                            in_has_echo, in_echo_width_us));

      // Register write; indexes past the list are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STOP_BELOW:   stop_thr   = cfg_data[DIST_W-1:0];
          CFG_TURN_BELOW:   turn_thr   = cfg_data[DIST_W-1:0];
          CFG_CRUISE_BELOW: cruise_thr = cfg_data[DIST_W-1:0];
          CFG_JUMP_LIMIT:   jump_max   = cfg_data[DIST_W-1:0];
          CFG_MIN_VALID:    min_dist   = cfg_data[DIST_W-1:0];
          CFG_STALE_MS:     stale_age  = cfg_data;
          CFG_TURN_GAP_MS:  turn_gap   = cfg_data;
          CFG_COOLDOWN_MS:  cool_len   = cfg_data;
          default: ;
        endcase
      end
    end
    beats_pending <= expected_cmds.size();
    mismatches    <= err_total;
  end

endmodule

[tb/tb.sv]
// Testbench top: drives passes and register writes into the speed governor.
`timescale 1ns / 1ps

module tb
  import uosg_pkg::*;
;

  localparam int      MAX_DIST_CFG  = 17983;
  localparam int      CFG_REG_COUNT = 8;
  localparam int      PHASES        = 7;
  localparam int      PHASE_PASSES  = 200;
  localparam int      RX_HOLD       = 120;
  localparam longint  LIMIT_NS      = 10_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  in_has_cmd = 1'b0;
  logic [CMD_W-1:0]      in_cmd_byte = '0;
  logic                  in_has_echo = 1'b0;
  logic [ECHO_W-1:0]     in_echo_width_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_motion;
  logic [RPM_W-1:0]      out_wheel_rpm;
  logic [DIST_W-1:0]     out_distance_used;

  int unsigned beats_pending;
  int unsigned mismatches;

  // Stimulus state
  bit                tx_idle = 1'b0;
  bit                rx_idle = 1'b0;
  int                hold_reqs = 0;
  bit                tx_running = 1'b0;
  logic [TIME_W-1:0] t_ms = '0;
  int                scene = 2500;
  int                min_valid_now = RST_MIN_VALID;

  ultrasonic_obstacle_speed_governor_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_ms         (in_now_ms),
    .in_has_cmd        (in_has_cmd),
    .in_cmd_byte       (in_cmd_byte),
    .in_has_echo       (in_has_echo),
    .in_echo_width_us  (in_echo_width_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motion        (out_motion),
    .out_wheel_rpm     (out_wheel_rpm),
    .out_distance_used (out_distance_used)
  );

  uosg_decision_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_ms         (in_now_ms),
    .in_has_cmd        (in_has_cmd),
    .in_cmd_byte       (in_cmd_byte),
    .in_has_echo       (in_has_echo),
    .in_echo_width_us  (in_echo_width_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motion        (out_motion),
    .out_wheel_rpm     (out_wheel_rpm),
    .out_distance_used (out_distance_used),
    .beats_pending     (beats_pending),
    .mismatches        (mismatches)
  );

  always #10 clk = ~clk;

  // Smallest echo width that converts to the given distance.
  function automatic int echo_for(input int dist_val);
    return (dist_val * 1024 + 280) / 281;
  endfunction

  // Offers one pass, after a random gap while tx_idle is set, and holds it until it is taken.
  task automatic send_pass(input logic [TIME_W-1:0] now, input logic has_cmd,
                           input logic [CMD_W-1:0] cmd, input logic has_echo,
                           input logic [ECHO_W-1:0] echo);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_now_ms        <= now;
    in_has_cmd       <= has_cmd;
    in_cmd_byte      <= cmd;
    in_has_echo      <= has_echo;
    in_echo_width_us <= echo;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted decision has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all registers, plus one index past the list that must be ignored.
  task automatic set_regs(input int stop_v, input int turn_v, input int cruise_v,
                          input int jump_v, input int minv_v, input int stale_v,
                          input int gap_v, input int cool_v);
    cfg_write(CFG_STOP_BELOW, CFG_DATA_W'(stop_v));
    cfg_write(CFG_TURN_BELOW, CFG_DATA_W'(turn_v));
    cfg_write(CFG_CRUISE_BELOW, CFG_DATA_W'(cruise_v));
    cfg_write(CFG_JUMP_LIMIT, CFG_DATA_W'(jump_v));
    cfg_write(CFG_MIN_VALID, CFG_DATA_W'(minv_v));
    cfg_write(CFG_STALE_MS, CFG_DATA_W'(stale_v));
    cfg_write(CFG_TURN_GAP_MS, CFG_DATA_W'(gap_v));
    cfg_write(CFG_COOLDOWN_MS, CFG_DATA_W'(cool_v));
    cfg_write(CFG_IDX_W'(CFG_REG_COUNT + $urandom_range(0, 7)),
              CFG_DATA_W'($urandom_range(0, 65535)));
    min_valid_now = minv_v;
  endtask

  // One random pass: mostly a drifting obstacle seen while running, with
  // time jumps, wraps, commands and junk echoes mixed in.
  task automatic random_pass();
    int unsigned       r;
    int                e;
    logic              has_cmd, has_echo;
    logic [CMD_W-1:0]  cmd;

    // Time stamp
    r = $urandom_range(0, 99);
    if (r < 2)       t_ms = $urandom();
    else if (r < 4)  t_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
    else if (r < 14) t_ms = t_ms + $urandom_range(0, 3000);
    else             t_ms = t_ms + $urandom_range(0, 80);

    // Command byte
    cmd     = CMD_W'($urandom_range(0, 255));
    has_cmd = 1'b0;
    r = $urandom_range(0, 99);
    if ((!tx_running && r < 30) || r < 2) begin
      has_cmd    = 1'b1;
      cmd        = CMD_START;
      tx_running = 1'b1;
    end else if (r < 4) begin
      has_cmd    = 1'b1;
      cmd        = CMD_STOP;
      tx_running = 1'b0;
    end else if (r < 8) begin
      has_cmd = 1'b1;
    end

    // Obstacle drift with an occasional jump
    if ($urandom_range(0, 99) < 4) scene = int'($urandom_range(100, 5000));
    else scene = scene + int'($urandom_range(0, 120)) - 60;
    if (scene < 0) scene = 0;
    if (scene > 5000) scene = 5000;

    // Echo width
    has_echo = $urandom_range(0, 99) < 85;
    r = $urandom_range(0, 99);
    if (r < 8)       e = int'($urandom_range(0, 65535));
    else if (r < 12) e = echo_for(MAX_VALID) + int'($urandom_range(0, 8)) - 4;
    else if (r < 16) e = echo_for(min_valid_now) + int'($urandom_range(0, 4)) - 2;
    else             e = echo_for(scene) + int'($urandom_range(0, 6)) - 3;
    if (e < 0) e = 0;
    if (e > 65535) e = 65535;

    send_pass(t_ms, has_cmd, cmd, has_echo, ECHO_W'(e));
  endtask

  // Result side: random stalls per beat while rx_idle is set, and a long hold-off on request.
  initial begin
    int unsigned rx_gap;
    int          holds_done;
    holds_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end
      rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (rx_gap != 0) begin
        out_ready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Main sequence
  initial begin
    int phase, i;
    int stop_v, turn_v, cruise_v;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed passes at reset settings
    send_pass(32'd10, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(1000)));  // not running yet
    send_pass(32'd20, 1'b1, 8'h32, 1'b0, 16'h0000);            // byte that is no command
    send_pass(32'd30, 1'b1, CMD_START, 1'b0, 16'h0000);        // running, no distance
    send_pass(32'd40, 1'b0, 8'h00, 1'b1, 16'h0000);            // zero echo
    send_pass(32'd50, 1'b0, 8'h00, 1'b1, 16'hFFFF);            // widest echo
    send_pass(32'd60, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(MAX_VALID))); // top of range
    send_pass(32'd70, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(MAX_VALID + 1)));
    send_pass(32'd80, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(RST_MIN_VALID) - 1));
    send_pass(32'd90, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(RST_MIN_VALID)));
    send_pass(32'd100, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(3000)));  // first median
    send_pass(32'd110, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(1000)));  // jump rejected
    send_pass(32'd120, 1'b1, CMD_STOP, 1'b1, ECHO_W'(echo_for(2000)));
    send_pass(32'd130, 1'b1, CMD_START, 1'b1, ECHO_W'(echo_for(800)));
    send_pass(32'd600, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(800)));   // partial set stale
    send_pass(32'd610, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(800)));
    send_pass(32'd620, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(800)));   // turn
    send_pass(32'd630, 1'b0, CMD_STOP, 1'b0, 16'h0000);        // byte without its flag
    send_pass(32'd640, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(699)));
    send_pass(32'd650, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(699)));
    send_pass(32'd660, 1'b0, 8'h00, 1'b1, ECHO_W'(echo_for(699)));   // turn blocked, slow
    send_pass(32'd670, 1'b1, 8'hCE, 1'b1, 16'hFFFF);
    send_pass(32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 16'h0000);     // turn at the wrap
    send_pass(32'd0, 1'b0, 8'h00, 1'b0, 16'h0000);
    t_ms       = '0;
    tx_running = 1'b1;
    wait_idle();

    // Random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: set_regs(0, 0, 0, 0, 0, 0, 0, 0);
        2: set_regs(MAX_DIST_CFG, MAX_DIST_CFG, MAX_DIST_CFG, MAX_DIST_CFG,
                    MAX_DIST_CFG, 65535, 65535, 65535);
        4: set_regs($urandom_range(0, MAX_VALID), $urandom_range(0, MAX_VALID),
                    $urandom_range(0, MAX_VALID), $urandom_range(0, MAX_DIST_CFG),
                    $urandom_range(0, 600), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
        5: set_regs(RST_STOP_BELOW, RST_TURN_BELOW, RST_CRUISE_BELOW, MAX_DIST_CFG,
                    RST_MIN_VALID, 65535, 0, 65535);
        default: begin
          stop_v   = $urandom_range(200, 700);
          turn_v   = stop_v + $urandom_range(0, 800);
          cruise_v = turn_v + $urandom_range(0, 1500);
          set_regs(stop_v, turn_v, cruise_v, $urandom_range(50, 1500),
                   $urandom_range(0, 400), $urandom_range(20, 600),
                   $urandom_range(0, 2000), $urandom_range(0, 3000));
        end
      endcase

      for (i = 0; i < PHASE_PASSES; i++) begin
        if (i % 50 == 0) begin
          tx_idle = $urandom_range(0, 1);
          rx_idle = $urandom_range(0, 1);
        end
        // Long result stall while passes keep coming, later a full drain.
        if (i == 60) hold_reqs++;
        if (i == 140) wait_idle();
        random_pass();
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && beats_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
hdl/uosg_pkg.sv
hdl/uosg_sample.sv
hdl/uosg_zone.sv
hdl/ultrasonic_obstacle_speed_governor_unit.sv
tb/uosg_decision_checker.sv
tb/tb.sv
